// ===== rtl/core/kmsd_pkg.sv =====
package kmsd_pkg;

  localparam int ROW_W   = 3;
  localparam int FIELD_W = 6;
  localparam int COL_W   = 3;
  localparam int CNT_W   = 6;

  localparam logic [FIELD_W-1:0] FIELD_MASK = 6'b111111;
  localparam logic [CNT_W-1:0]   COUNT_MAX  = 6'd63;
  localparam logic [CNT_W-1:0]   COUNT_ONE  = 6'd1;

  // One scanned row sample
  typedef struct packed {
    logic [ROW_W-1:0]   row_index;
    logic [FIELD_W-1:0] column_bits;
  } in_t;

  // One key event
  typedef struct packed {
    logic [ROW_W-1:0] event_row;
    logic [COL_W-1:0] event_column;
    logic             pressed;
    logic [CNT_W-1:0] keys_down;
    logic             last_event;
  } out_t;

  // Changed keys of one row, handed to the event sequencer
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [FIELD_W-1:0] mask;
    logic [FIELD_W-1:0] deb;
  } job_t;

endpackage

// ===== rtl/core/kmsd_emit.sv =====
module kmsd_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  kmsd_pkg::job_t job,
  output logic          job_free,
  output logic          out_valid,
  input  logic          out_ready,
  output kmsd_pkg::out_t out_data
);

  logic                          em_valid_r;
  kmsd_pkg::job_t                em_r;
  logic [kmsd_pkg::CNT_W-1:0]    cnt_r;
  logic [kmsd_pkg::CNT_W-1:0]    cnt_nxt;
  logic                          out_valid_r;
  kmsd_pkg::out_t                out_data_r;
  logic [kmsd_pkg::COL_W-1:0]    col;
  logic [kmsd_pkg::FIELD_W-1:0]  rest;
  logic                          is_press;
  logic                          em_step;
  logic                          em_last;

  // Pick the lowest changed column
  always_comb begin
    col = '0;
    for (int c = kmsd_pkg::FIELD_W - 1; c >= 0; c--) begin
      if (em_r.mask[c]) col = kmsd_pkg::COL_W'(c);
    end
  end

  assign rest     = em_r.mask & (em_r.mask - kmsd_pkg::FIELD_W'(1));
  assign is_press = em_r.deb[col];
  assign em_last  = (rest == '0);
  assign em_step  = em_valid_r && (!out_valid_r || out_ready);
  assign job_free = !em_valid_r || (em_step && em_last);

  // Saturating key count
  always_comb begin
    cnt_nxt = cnt_r;
    if (is_press) begin
      if (cnt_r != kmsd_pkg::COUNT_MAX) cnt_nxt = cnt_r + kmsd_pkg::COUNT_ONE;
    end else begin
      if (cnt_r != '0) cnt_nxt = cnt_r - kmsd_pkg::COUNT_ONE;
    end
  end

  // Advance the sequencer and hold the output transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (em_step) begin
        out_valid_r             <= 1'b1;
        out_data_r.event_row    <= em_r.row;
        out_data_r.event_column <= col;
        out_data_r.pressed      <= is_press;
        out_data_r.keys_down    <= cnt_nxt;
        out_data_r.last_event   <= em_last;
        cnt_r                   <= cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Load a new job, or drop the column just sent from the current one
      if (job_valid) begin
        em_valid_r <= 1'b1;
        em_r       <= job;
      end else if (em_step) begin
        em_r.mask <= rest;
        if (em_last) em_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/key_matrix_scan_debounce.sv =====
// Key matrix row scanner with two-sample debounce. Each input transaction is
// one raw row sample; a key is debounced-pressed when this and the previous
// sample of its row both show it. Per-row state (previous sample and
// debounced bits) lives in a ROWS-deep memory with a registered read, so a
// sample is read on acceptance and written back once its changes are handed
// to the event sequencer, with same-row forwarding between consecutive
// samples. Changed keys leave as one output transaction per cycle while the
// output is not stalled, lowest column first, each with the updated
// saturating count of keys held down; the last one of a sample is marked.
// A sample passes through the lookup stage, the event sequencer's register
// and the output register before its first event is offered (a sample with
// no change leaves from the lookup stage, an out-of-range row is dropped on
// acceptance), and the next sample is accepted while the previous one's
// events are still leaving, then waits in the lookup stage until the
// sequencer takes the last of them. Columns at or above COLS or above bit 5
// are ignored. Row memory comes out of reset cleared through per-row valid
// flags, with no clearing pass.
module key_matrix_scan_debounce #(
  parameter int ROWS = 4,
  parameter int COLS = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kmsd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kmsd_pkg::out_t out_data
);

  localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EFF   = (COLS < kmsd_pkg::FIELD_W) ? COLS : kmsd_pkg::FIELD_W;
  localparam int FW    = kmsd_pkg::FIELD_W;
  localparam logic [FW-1:0] COL_MASK = FW'((7'd1 << EFF) - 7'd1);
  localparam logic [kmsd_pkg::ROW_W:0] ROWS_LIM = (kmsd_pkg::ROW_W + 1)'(ROWS);

  logic [2*FW-1:0]            mem [ROWS];
  logic [ROWS-1:0]            row_vld_r;
  logic                       rd_valid_r;
  logic [kmsd_pkg::ROW_W-1:0] rd_row_r;
  logic [FW-1:0]              rd_sample_r;
  logic [2*FW-1:0]            rd_q_r;
  logic                       rd_vld_r;
  logic                       fwd_sel_r;
  logic [2*FW-1:0]            fwd_q_r;
  logic [2*FW-1:0]            base;
  logic [2*FW-1:0]            wr_data;
  logic [FW-1:0]              new_deb;
  logic [FW-1:0]              diff;
  logic [AW-1:0]              in_idx;
  logic [AW-1:0]              rd_idx;
  logic                       in_ok;
  logic                       in_acc;
  logic                       rd_go;
  logic                       job_valid;
  logic                       job_free;
  kmsd_pkg::job_t             job;

  assign in_idx = in_data.row_index[AW-1:0];
  assign rd_idx = rd_row_r[AW-1:0];
  assign in_ok  = ({1'b0, in_data.row_index} < ROWS_LIM);
  assign in_acc = in_valid && in_ready;

  // Merge forwarded, stored and reset-state row data
  always_comb begin
    if (fwd_sel_r)     base = fwd_q_r;
    else if (rd_vld_r) base = rd_q_r;
    else               base = '0;
  end

  assign new_deb = base[2*FW-1:FW] & rd_sample_r;
  assign diff    = (base[FW-1:0] ^ new_deb) & COL_MASK;
  assign wr_data = {rd_sample_r, new_deb};

  // Retire the looked-up row once the sequencer can take its changes
  assign rd_go     = rd_valid_r && ((diff == '0) || job_free);
  assign in_ready  = !rd_valid_r || rd_go;
  assign job_valid = rd_go && (diff != '0);
  assign job.row   = rd_row_r;
  assign job.mask  = diff;
  assign job.deb   = new_deb;

  // Row memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (in_acc && in_ok) rd_q_r <= mem[in_idx];
    if (rd_go) mem[rd_idx] <= wr_data;
  end

  // Lookup stage control, row valid flags and same-row forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      row_vld_r  <= '0;
      fwd_sel_r  <= 1'b0;
    end else begin
      if (rd_go) row_vld_r[rd_idx] <= 1'b1;
      if (in_acc && in_ok) begin
        rd_valid_r  <= 1'b1;
        rd_row_r    <= in_data.row_index;
        rd_sample_r <= in_data.column_bits & COL_MASK;
        rd_vld_r    <= row_vld_r[in_idx];
        fwd_sel_r   <= rd_go && (rd_idx == in_idx);
        fwd_q_r     <= wr_data;
      end else if (rd_go) begin
        rd_valid_r <= 1'b0;
      end
    end
  end

  kmsd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_free  (job_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/kmsd_check.sv =====
module kmsd_check (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input kmsd_pkg::out_t out_data
);

  logic out_acc;
  assign out_acc = out_valid && out_ready;

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output transaction dropped or changed while stalled");

  // Come out of reset with no output pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Follow a non-final event at once with a higher column of the same row
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_data.last_event) |=>
      (out_valid && out_data.event_row == $past(out_data.event_row) &&
       out_data.event_column > $past(out_data.event_column)))
    else $error("event run broken or out of column order");

  // Step the key count by one within a run, saturating at its bounds
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_data.last_event) |=>
      (out_data.pressed ?
        (out_data.keys_down == 6'($past(out_data.keys_down) + 6'd1) ||
         $past(out_data.keys_down) == 6'd63) :
        (out_data.keys_down == 6'($past(out_data.keys_down) - 6'd1) ||
         $past(out_data.keys_down) == 6'd0)))
    else $error("key count stepped wrongly");

  // Report only existing columns
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.event_column < 3'd6))
    else $error("event column out of range");

endmodule

bind key_matrix_scan_debounce kmsd_check u_kmsd_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
